// ----- sv/psrc_pkg.sv -----
// Package for the safe-region check: types, sizes and the constraint tables.
`timescale 1ns / 1ps
`default_nettype none
package psrc_pkg;

	localparam int CONSTRAINT_ROWS = 38;
	localparam int ROW_W = 6;
	localparam int CNT_W = (CONSTRAINT_ROWS > 1) ? $clog2(CONSTRAINT_ROWS) : 1;
	localparam int LANES = 4;
	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W = PROD_W + $clog2(LANES);
	localparam int FRAC_SHIFT = 14;

	typedef struct packed {
		logic signed [DATA_W-1:0] elevation_angle;
		logic signed [DATA_W-1:0] pitch_angle;
		logic signed [DATA_W-1:0] travel_angle;
		logic signed [DATA_W-1:0] elevation_rate;
		logic signed [DATA_W-1:0] pitch_rate;
		logic signed [DATA_W-1:0] travel_rate;
	} state_in_t;

	typedef struct packed {
		logic             inside_safe_set;
		logic [ROW_W-1:0] first_failed_row;
	} result_t;

	// row tag that travels down the pipeline next to the data
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [ROW_W-1:0] row;
	} row_ctl_t;

	typedef struct packed {
		row_ctl_t ctl;
		logic     fail;
	} merge_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

	// weights for elevation, pitch, elevation rate, pitch rate (Q2.14)
	typedef logic [0:LANES-1][DATA_W-1:0] coef_row_t;

	function automatic coef_row_t coef_row(input logic [ROW_W-1:0] r);
		coef_row_t c;
		case (r)
			6'd0:  c = {-16'sd15364, -16'sd5690,  16'sd0,     16'sd0};
			6'd1:  c = { 16'sd16384,  16'sd0,     16'sd0,     16'sd0};
			6'd2:  c = { 16'sd0,      16'sd0,     16'sd16384, 16'sd0};
			6'd3:  c = { 16'sd0,      16'sd0,     16'sd0,     16'sd16384};
			6'd4:  c = {-16'sd15364,  16'sd5690,  16'sd0,     16'sd0};
			6'd5:  c = {-16'sd16384,  16'sd0,     16'sd0,     16'sd0};
			6'd6:  c = { 16'sd0,      16'sd0,    -16'sd16384, 16'sd0};
			6'd7:  c = { 16'sd0,      16'sd0,     16'sd0,    -16'sd16384};
			6'd8:  c = {-16'sd15087,  16'sd5588, -16'sd3017,  16'sd702};
			6'd9:  c = { 16'sd16066,  16'sd0,     16'sd3213,  16'sd0};
			6'd10: c = { 16'sd15993,  16'sd1523,  16'sd3199,  16'sd305};
			6'd11: c = { 16'sd15993, -16'sd1523,  16'sd3199, -16'sd305};
			6'd12: c = { 16'sd16103,  16'sd436,   16'sd2985,  16'sd175};
			6'd13: c = { 16'sd16111,  16'sd554,   16'sd2923,  16'sd180};
			6'd14: c = {-16'sd16066,  16'sd0,    -16'sd3213,  16'sd0};
			6'd15: c = {-16'sd15441, -16'sd2913, -16'sd4603, -16'sd583};
			6'd16: c = {-16'sd15087, -16'sd5588, -16'sd3017, -16'sd702};
			6'd17: c = {-16'sd15394,  16'sd3761, -16'sd4114,  16'sd621};
			6'd18: c = {-16'sd15234,  16'sd4052, -16'sd4413,  16'sd680};
			6'd19: c = {-16'sd15484,  16'sd3392, -16'sd4103,  16'sd583};
			6'd20: c = { 16'sd11966, -16'sd7039,  16'sd8587, -16'sd1408};
			6'd21: c = { 16'sd11966,  16'sd7039,  16'sd8587,  16'sd1408};
			6'd22: c = { 16'sd16111, -16'sd554,   16'sd2923, -16'sd180};
			6'd23: c = { 16'sd16103, -16'sd436,   16'sd2985, -16'sd175};
			6'd24: c = {-16'sd15066, -16'sd5580, -16'sd3013, -16'sd1116};
			6'd25: c = {-16'sd15234, -16'sd4052, -16'sd4413, -16'sd680};
			6'd26: c = {-16'sd15484, -16'sd3392, -16'sd4103, -16'sd583};
			6'd27: c = {-16'sd15144,  16'sd1442, -16'sd6057,  16'sd577};
			6'd28: c = {-16'sd15441,  16'sd2913, -16'sd4603,  16'sd583};
			6'd29: c = {-16'sd15993,  16'sd1523, -16'sd3199,  16'sd305};
			6'd30: c = {-16'sd15445,  16'sd3664, -16'sd4013,  16'sd602};
			6'd31: c = {-16'sd15066,  16'sd5580, -16'sd3013,  16'sd1116};
			6'd32: c = {-16'sd15445, -16'sd3664, -16'sd4013, -16'sd602};
			6'd33: c = {-16'sd15394, -16'sd3761, -16'sd4114, -16'sd621};
			6'd34: c = {-16'sd15993, -16'sd1523, -16'sd3199, -16'sd305};
			6'd35: c = {-16'sd15144, -16'sd1442, -16'sd6057, -16'sd577};
			6'd36: c = { 16'sd15144,  16'sd1442,  16'sd6057,  16'sd577};
			6'd37: c = { 16'sd15144, -16'sd1442,  16'sd6057, -16'sd577};
			default: c = '0; // padding rows: zero weights, zero bound
		endcase
		return c;
	endfunction

	// row bounds, Q4.12
	function automatic logic signed [DATA_W-1:0] bound_row(input logic [ROW_W-1:0] r);
		logic signed [DATA_W-1:0] b;
		case (r) inside
			6'd0, 6'd4:                      b = 16'sd471;
			6'd1, 6'd5:                      b = 16'sd490;
			6'd2, 6'd6:                      b = 16'sd818;
			6'd3, 6'd7:                      b = 16'sd5325;
			6'd8, 6'd16:                     b = 16'sd672;
			6'd9, 6'd14, 6'd29, 6'd34:       b = 16'sd561;
			6'd10, 6'd11:                    b = 16'sd807;
			6'd12, 6'd23:                    b = 16'sd645;
			6'd13, 6'd22:                    b = 16'sd659;
			6'd15, 6'd28:                    b = 16'sd658;
			6'd17, 6'd33:                    b = 16'sd642;
			6'd18, 6'd25:                    b = 16'sd678;
			6'd19, 6'd26:                    b = 16'sd625;
			6'd20, 6'd21:                    b = 16'sd2033;
			6'd24, 6'd31:                    b = 16'sd754;
			6'd27, 6'd35:                    b = 16'sd759;
			6'd30, 6'd32:                    b = 16'sd630;
			6'd36, 6'd37:                    b = 16'sd992;
			default:                         b = 16'sd0;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ----- sv/polytope_safe_region_check_top.sv -----
// Top level of the safe-region check: row sequencer, four lanes, merge and output register.
//
// Tests one plant state against CONSTRAINT_ROWS half-space rows. Four multiply lanes
// (elevation, pitch, elevation rate, pitch rate; the travel terms have zero weight) form
// one row's dot product each cycle, and a two-stage merge sums and compares it with the
// row bound. Every row is visited, one row per cycle by the sequencer, and an item holds
// the block until its last row has left the merge and its result is loaded.
// in_ready is high only between items; a finished result sits in the output register
// and the next item may be taken while it waits. A product equal to its bound passes;
// first_failed_row is the lowest failing row, 0 when the state is inside.
`timescale 1ns / 1ps
`default_nettype none
module polytope_safe_region_check_top import psrc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire state_in_t in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output result_t        out_data
);

	seq_state_t               st_q, st_d;
	logic                     issue, out_load, in_acc, last_row;
	logic [CNT_W-1:0]         issue_q;
	logic [ROW_W-1:0]         row;
	state_in_t                state_q;
	coef_row_t                coefs;
	logic signed [DATA_W-1:0] xs [LANES];
	logic signed [PROD_W-1:0] prod_s1 [LANES];
	logic signed [DATA_W-1:0] bound_s1;
	row_ctl_t                 ctl_s1;
	merge_out_t               mo;
	logic                     found_q;
	logic [ROW_W-1:0]         frow_q;

	assign in_ready = (st_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign row = ROW_W'(issue_q);
	assign last_row = (issue_q == CNT_W'(CONSTRAINT_ROWS - 1));
	assign coefs = coef_row(row);

	assign xs[0] = state_q.elevation_angle;
	assign xs[1] = state_q.pitch_angle;
	assign xs[2] = state_q.elevation_rate;
	assign xs[3] = state_q.pitch_rate;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		psrc_lane u_lane (
			.clk     (clk),
			.coef    ($signed(coefs[k])),
			.x       (xs[k]),
			.prod_s1 (prod_s1[k])
		);
	end

	psrc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.prod_s1  (prod_s1),
		.bound_s1 (bound_s1),
		.ctl_s1   (ctl_s1),
		.res_s3   (mo)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			state_q <= in_data;
		end
		bound_s1 <= bound_row(row);
		if (out_load) begin
			out_data.inside_safe_set <= !found_q;
			out_data.first_failed_row <= frow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			issue_q <= '0;
			ctl_s1 <= '0;
			found_q <= 1'b0;
			frow_q <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (in_acc) begin
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			ctl_s1.vld <= issue;
			ctl_s1.last <= last_row;
			ctl_s1.row <= row;
			// keep only the lowest failing row
			if (in_acc) begin
				found_q <= 1'b0;
				frow_q <= '0;
			end else if (mo.ctl.vld && mo.fail && !found_q) begin
				found_q <= 1'b1;
				frow_q <= mo.ctl.row;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		issue = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (last_row) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mo.ctl.vld && mo.ctl.last) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (st_q == ST_RUN) && (issue_q == '0))
		else $error("item accepted but row scan did not start at row zero");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ctl_s1.vld && !mo.ctl.vld)
		else $error("rows still in flight while taking a new item");

	a_inside_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_safe_set |-> out_data.first_failed_row == '0)
		else $error("failed row reported for a safe state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid || out_ready)
		else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

// ----- sv/psrc_lane.sv -----
// One multiply lane: coefficient times state element, registered.
`timescale 1ns / 1ps
`default_nettype none
module psrc_lane import psrc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [DATA_W-1:0] coef,
	input  wire logic signed [DATA_W-1:0] x,
	output logic signed [PROD_W-1:0]      prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= coef * x;
	end

endmodule
`default_nettype wire

// ----- sv/psrc_merge.sv -----
// Merge stage: sums the lane products and compares against the scaled row bound.
`timescale 1ns / 1ps
`default_nettype none
module psrc_merge import psrc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic signed [PROD_W-1:0] prod_s1 [LANES],
	input  wire logic signed [DATA_W-1:0] bound_s1,
	input  wire row_ctl_t                 ctl_s1,
	output merge_out_t                    res_s3
);

	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [DATA_W-1:0] bound_s2;
	row_ctl_t                 ctl_s2;
	logic signed [SUM_W-1:0]  lim;
	row_ctl_t                 ctl_s3;
	logic                     fail_s3;

	// bound moved to the product scale (Q.26)
	assign lim = SUM_W'($signed({bound_s2, {FRAC_SHIFT{1'b0}}}));

	assign res_s3 = '{ctl: ctl_s3, fail: fail_s3};

	always_ff @(posedge clk) begin
		sum_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1])
			+ SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]);
		bound_s2 <= bound_s1;
		fail_s3 <= sum_s2 > lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

`ifndef SYNTHESIS
	// the scaled bound keeps the sign of the row bound
	a_lim_sign: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.vld |-> (lim[SUM_W-1] == bound_s2[DATA_W-1]))
		else $error("scaled bound lost its sign");
`endif

endmodule
`default_nettype wire
